// File: rtl/srr_pkg.sv
package srr_pkg;

	localparam int SEQ_W      = 16;
	localparam int TAG_W      = 32;
	localparam int LEN_W      = 11;
	localparam int FRAME_W    = TAG_W + LEN_W;
	localparam int ITEM_W     = SEQ_W + TAG_W + LEN_W;
	localparam int TDATA_W    = ((ITEM_W + 7) / 8) * 8;
	localparam int TUSER_W    = 2;
	localparam int WS_W       = 5;
	localparam int FC_W       = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int BITCNT_W   = $clog2(SEQ_W);

	localparam logic [CFG_IDX_W-1:0] CFG_WIN_SLOTS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	localparam logic [WS_W-1:0] WIN_SLOTS_RESET   = 5'd16;
	localparam logic [FC_W-1:0] FRAME_COUNT_RESET = 16'hFFFF;

	typedef struct packed {
		logic [LEN_W-1:0] payload_len;
		logic [TAG_W-1:0] payload_tag;
		logic [SEQ_W-1:0] seq_num;
	} srr_item_t;

	typedef struct packed {
		logic             all_done;
		logic             last_of_run;
		logic             result_kind;
		logic [LEN_W-1:0] out_len;
		logic [TAG_W-1:0] out_tag;
		logic [SEQ_W-1:0] out_seq;
	} srr_result_t;

	typedef struct packed {
		logic      valid;
		srr_item_t item;
	} srr_head_t;

endpackage

// File: rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver. Each accepted frame is acknowledged, and a frame
// that falls in the receive window is buffered; whenever the expected frame is
// present, the run of consecutive buffered frames is delivered in order ahead of
// the acknowledgement, which always ends the frame's results with tlast set. A
// two-entry input queue and an output register let both sides stall on their own.
// A frame outside the window goes from ST_IDLE to ST_ACK; a frame inside it goes to
// ST_READ and, for each frame it releases, through ST_DLV and back to ST_READ: the slot
// memory has one registered read port, so every delivery reads the slot in ST_READ and
// loads the output register in ST_DLV. Writing the window register starts a 16-step
// bit-serial remainder of the expected sequence number by the new window, and queued
// frames are held back while it runs and its result is taken.
module selective_repeat_receiver #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// seq_num, payload_tag, payload_len, zero padding.
	input  logic [srr_pkg::TDATA_W-1:0]       s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_seq, out_tag, out_len, zero padding.
	output logic [srr_pkg::TDATA_W-1:0]       m_tdata,
	// result_kind, all_done.
	output logic [srr_pkg::TUSER_W-1:0]       m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_wen,
	input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WW = $clog2(WINDOW_DEPTH + 1);

	function automatic logic [WW-1:0] eff_window(input logic [srr_pkg::WS_W-1:0] ws);
		logic [WW-1:0] w;
		if (int'(ws) > WINDOW_DEPTH) begin
			w = WW'(WINDOW_DEPTH);
		end else if (ws == '0) begin
			w = WW'(1);
		end else begin
			w = WW'(ws);
		end
		return w;
	endfunction

	logic [srr_pkg::WS_W-1:0]    win_slots_q;
	logic [srr_pkg::FC_W-1:0]    frame_count_q;
	logic [WW-1:0]               win;
	logic                        rem_start;
	logic                        rem_busy;
	logic                        rem_done;
	logic [IW-1:0]               rem;
	logic [srr_pkg::SEQ_W-1:0]   expected_seq;
	srr_pkg::srr_head_t          head;
	logic                        pop;
	srr_pkg::srr_result_t        result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_slots_q   <= srr_pkg::WIN_SLOTS_RESET;
			frame_count_q <= srr_pkg::FRAME_COUNT_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				srr_pkg::CFG_WIN_SLOTS:   win_slots_q   <= cfg_data[srr_pkg::WS_W-1:0];
				srr_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data[srr_pkg::FC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign win       = eff_window(win_slots_q);
	assign rem_start = cfg_wen && (cfg_index == srr_pkg::CFG_WIN_SLOTS);

	srr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.head     (head),
		.pop      (pop)
	);

	srr_remu #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_remu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (expected_seq),
		.divisor  (eff_window(cfg_data[srr_pkg::WS_W-1:0])),
		.busy     (rem_busy),
		.done     (rem_done),
		.rem      (rem)
	);

	srr_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.win          (win),
		.frame_count  (frame_count_q),
		.head         (head),
		.pop          (pop),
		.rem_busy     (rem_busy),
		.rem_done     (rem_done),
		.rem          (rem),
		.expected_seq (expected_seq),
		.m_valid      (m_tvalid),
		.m_ready      (m_tready),
		.result       (result)
	);

	assign m_tdata = srr_pkg::TDATA_W'({result.out_len, result.out_tag, result.out_seq});
	assign m_tuser = {result.all_done, result.result_kind};
	assign m_tlast = result.last_of_run;

	a_ack_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (result.result_kind == srr_pkg::KIND_ACK)
		|-> (result.out_tag == '0) && (result.out_len == '0))
		else $error("Acknowledgement carries a payload.");

	a_last_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result.last_of_run == (result.result_kind == srr_pkg::KIND_ACK)))
		else $error("Run end does not coincide with the acknowledgement.");

	a_no_pop_in_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_busy || rem_done) |-> !pop)
		else $error("Frame taken while the expected slot is being recomputed.");

endmodule

// File: rtl/srr_front.sv
module srr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [srr_pkg::TDATA_W-1:0]  s_tdata,
	output srr_pkg::srr_head_t           head,
	input  logic                         pop
);

	srr_pkg::srr_item_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= srr_pkg::srr_item_t'(s_tdata[srr_pkg::ITEM_W-1:0]);
		end
	end

endmodule

// File: rtl/srr_remu.sv
module srr_remu #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [srr_pkg::SEQ_W-1:0]                  dividend,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0]          divisor,
	output logic                                       busy,
	output logic                                       done,
	output logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] rem
);

	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WW = $clog2(WINDOW_DEPTH + 1);
	localparam int RW = IW + 1;

	logic                             busy_q;
	logic                             done_q;
	logic [srr_pkg::BITCNT_W-1:0]     cnt_q;
	logic [srr_pkg::SEQ_W-1:0]        num_q;
	logic [WW-1:0]                    div_q;
	logic [IW-1:0]                    rem_q;
	logic [RW-1:0]                    trial;
	logic [IW-1:0]                    rem_next;

	always_comb begin
		trial = {rem_q, num_q[srr_pkg::SEQ_W-1]};
		if (trial >= RW'(div_q)) begin
			rem_next = IW'(trial - RW'(div_q));
		end else begin
			rem_next = IW'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			div_q  <= WW'(1);
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= rem_next;
				num_q <= {num_q[srr_pkg::SEQ_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == srr_pkg::BITCNT_W'(srr_pkg::SEQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/srr_back.sv
module srr_back #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0]          win,
	input  logic [srr_pkg::FC_W-1:0]                   frame_count,
	input  srr_pkg::srr_head_t                         head,
	output logic                                       pop,
	input  logic                                       rem_busy,
	input  logic                                       rem_done,
	input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] rem,
	output logic [srr_pkg::SEQ_W-1:0]                  expected_seq,
	output logic                                       m_valid,
	input  logic                                       m_ready,
	output srr_pkg::srr_result_t                       result
);

	localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WW = $clog2(WINDOW_DEPTH + 1);
	localparam int RW = IW + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DLV,
		ST_ACK
	} state_t;

	state_t                           state_q;
	logic [srr_pkg::SEQ_W-1:0]        exp_q;
	logic [IW-1:0]                    exp_slot_q;
	logic [srr_pkg::SEQ_W-1:0]        count_q;
	logic [WW-1:0]                    n_q;
	logic [WINDOW_DEPTH-1:0]          mark_q;
	logic [srr_pkg::SEQ_W-1:0]        ack_seq_q;
	logic                             out_valid_q;
	srr_pkg::srr_result_t             out_q;

	logic [srr_pkg::FRAME_W-1:0]      frame_mem [WINDOW_DEPTH];
	logic [srr_pkg::FRAME_W-1:0]      rd_q;

	logic                             done_now;
	logic                             done_after;
	logic [srr_pkg::SEQ_W-1:0]        offset;
	logic                             in_win;
	logic [RW-1:0]                    sum;
	logic [IW-1:0]                    slot_new;
	logic                             can_load;
	logic                             load;
	logic                             more;
	logic [IW-1:0]                    exp_slot_next;

	always_comb begin
		done_now   = (count_q >= frame_count);
		done_after = ({1'b0, count_q} + 17'd1) >= {1'b0, frame_count};
		offset     = head.item.seq_num - exp_q;
		in_win     = (offset < srr_pkg::SEQ_W'(win)) && !done_now;
		sum        = RW'(exp_slot_q) + RW'(offset[IW-1:0]);
		if (sum >= RW'(win)) begin
			slot_new = IW'(sum - RW'(win));
		end else begin
			slot_new = IW'(sum);
		end
		pop      = (state_q == ST_IDLE) && head.valid && !rem_busy && !rem_done;
		can_load = !out_valid_q || m_ready;
		more     = mark_q[exp_slot_q] && !done_now && (n_q < win);
		load     = can_load && (((state_q == ST_READ) && !more) || (state_q == ST_DLV) ||
			(state_q == ST_ACK));
		if ((RW'(exp_slot_q) + RW'(1'b1)) == RW'(win)) begin
			exp_slot_next = '0;
		end else begin
			exp_slot_next = exp_slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			exp_slot_q  <= '0;
			count_q     <= '0;
			n_q         <= '0;
			mark_q      <= '0;
			ack_seq_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rem_done) begin
				exp_slot_q <= rem;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						ack_seq_q <= head.item.seq_num;
						n_q       <= '0;
						if (in_win) begin
							mark_q[slot_new] <= 1'b1;
							state_q          <= ST_READ;
						end else begin
							state_q <= ST_ACK;
						end
					end
				end
				ST_READ: begin
					if (more) begin
						state_q <= ST_DLV;
					end else if (can_load) begin
						out_q.result_kind <= srr_pkg::KIND_ACK;
						out_q.out_seq     <= ack_seq_q;
						out_q.out_tag     <= '0;
						out_q.out_len     <= '0;
						out_q.last_of_run <= 1'b1;
						out_q.all_done    <= done_now;
						state_q           <= ST_IDLE;
					end
				end
				ST_DLV: begin
					if (can_load) begin
						out_q.result_kind    <= srr_pkg::KIND_DELIVER;
						out_q.out_seq        <= exp_q;
						out_q.out_tag        <= rd_q[srr_pkg::FRAME_W-1:srr_pkg::LEN_W];
						out_q.out_len        <= rd_q[srr_pkg::LEN_W-1:0];
						out_q.last_of_run    <= 1'b0;
						out_q.all_done       <= done_after;
						mark_q[exp_slot_q]   <= 1'b0;
						exp_q                <= exp_q + 1'b1;
						exp_slot_q           <= exp_slot_next;
						count_q              <= count_q + 1'b1;
						n_q                  <= n_q + 1'b1;
						state_q              <= ST_READ;
					end
				end
				ST_ACK: begin
					if (can_load) begin
						out_q.result_kind <= srr_pkg::KIND_ACK;
						out_q.out_seq     <= ack_seq_q;
						out_q.out_tag     <= '0;
						out_q.out_len     <= '0;
						out_q.last_of_run <= 1'b1;
						out_q.all_done    <= done_now;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && in_win) begin
			frame_mem[slot_new] <= {head.item.payload_tag, head.item.payload_len};
		end
		rd_q <= frame_mem[exp_slot_q];
	end

	assign expected_seq = exp_q;
	assign m_valid      = out_valid_q;
	assign result       = out_q;

endmodule

// File: verif/srr_delivery_checker.sv
`timescale 1ns / 1ps

module srr_delivery_checker #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	// seq_num, payload_tag, payload_len, zero padding.
	input  logic [srr_pkg::TDATA_W-1:0]       s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// out_seq, out_tag, out_len, zero padding.
	input  logic [srr_pkg::TDATA_W-1:0]       m_tdata,
	// result_kind, all_done.
	input  logic [srr_pkg::TUSER_W-1:0]       m_tuser,
	input  logic                              m_tlast,
	input  logic                              cfg_wen,
	input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int unsigned                       failures,
	output int unsigned                       pending,
	output int unsigned                       deliveries_seen,
	output int unsigned                       acks_seen
);

	logic [srr_pkg::WS_W-1:0]  window_reg;
	logic [srr_pkg::FC_W-1:0]  frame_total;
	logic [srr_pkg::SEQ_W-1:0] next_seq;
	logic [srr_pkg::SEQ_W-1:0] released;
	logic                      held [WINDOW_DEPTH];
	logic [srr_pkg::TAG_W-1:0] held_tag [WINDOW_DEPTH];
	logic [srr_pkg::LEN_W-1:0] held_len [WINDOW_DEPTH];
	srr_pkg::srr_result_t      awaited_results [$];

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		failures++;
	endtask

	function automatic int unsigned live_window();
		if (window_reg == 0) begin
			return 1;
		end
		if (window_reg > WINDOW_DEPTH) begin
			return WINDOW_DEPTH;
		end
		return 32'(window_reg);
	endfunction

	function automatic logic transfer_done();
		return released >= frame_total;
	endfunction

	task automatic predict_frame_results(input srr_pkg::srr_item_t frame);
		int unsigned w;
		int unsigned slot;
		int unsigned n;
		logic [srr_pkg::SEQ_W-1:0] offset;
		srr_pkg::srr_result_t r;
		w = live_window();
		offset = frame.seq_num - next_seq;
		n = 0;
		if (offset < w && !transfer_done()) begin
			slot = frame.seq_num % w;
			held[slot] = 1'b1;
			held_tag[slot] = frame.payload_tag;
			held_len[slot] = frame.payload_len;
			while (n < w && !transfer_done() && held[next_seq % w]) begin
				slot = next_seq % w;
				held[slot] = 1'b0;
				released = released + 1'b1;
				r.result_kind = srr_pkg::KIND_DELIVER;
				r.out_seq = next_seq;
				r.out_tag = held_tag[slot];
				r.out_len = held_len[slot];
				r.last_of_run = 1'b0;
				r.all_done = transfer_done();
				awaited_results.push_back(r);
				next_seq = next_seq + 1'b1;
				n++;
			end
		end
		r.result_kind = srr_pkg::KIND_ACK;
		r.out_seq = frame.seq_num;
		r.out_tag = '0;
		r.out_len = '0;
		r.last_of_run = 1'b1;
		r.all_done = transfer_done();
		awaited_results.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want, input logic [srr_pkg::SEQ_W-1:0] seq);
		if (got !== want) begin
			report_mismatch($sformatf("%s for seq %0d: got %0h, expected %0h",
				name, seq, got, want));
		end
	endtask

	task automatic check_result();
		srr_pkg::srr_result_t want;
		srr_pkg::srr_item_t got;
		got = m_tdata[srr_pkg::ITEM_W-1:0];
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result for seq %0d with nothing expected", got.seq_num));
		end else begin
			want = awaited_results.pop_front();
			compare_field("result_kind", 32'(m_tuser[0]), 32'(want.result_kind), want.out_seq);
			compare_field("out_seq", 32'(got.seq_num), 32'(want.out_seq), want.out_seq);
			compare_field("out_tag", got.payload_tag, want.out_tag, want.out_seq);
			compare_field("out_len", 32'(got.payload_len), 32'(want.out_len), want.out_seq);
			compare_field("last_of_run", 32'(m_tlast), 32'(want.last_of_run), want.out_seq);
			compare_field("all_done", 32'(m_tuser[1]), 32'(want.all_done), want.out_seq);
			compare_field("padding", 32'(m_tdata[srr_pkg::TDATA_W-1:srr_pkg::ITEM_W]), '0,
				want.out_seq);
			if (want.result_kind == srr_pkg::KIND_ACK) begin
				acks_seen++;
			end else begin
				deliveries_seen++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = srr_pkg::WIN_SLOTS_RESET;
			frame_total = srr_pkg::FRAME_COUNT_RESET;
			next_seq = '0;
			released = '0;
			failures = 0;
			deliveries_seen = 0;
			acks_seen = 0;
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				held[i] = 1'b0;
			end
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (cfg_wen) begin
				if (cfg_index == srr_pkg::CFG_WIN_SLOTS) begin
					window_reg = cfg_data[srr_pkg::WS_W-1:0];
				end else if (cfg_index == srr_pkg::CFG_FRAME_COUNT) begin
					frame_total = cfg_data[srr_pkg::FC_W-1:0];
				end
			end
			if (s_tvalid && s_tready) begin
				predict_frame_results(s_tdata[srr_pkg::ITEM_W-1:0]);
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// File: verif/tb_selective_repeat_receiver.sv
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;

	localparam int DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PHASE_FRAMES = 45;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [srr_pkg::TDATA_W-1:0]    s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [srr_pkg::TDATA_W-1:0]    m_tdata;
	logic [srr_pkg::TUSER_W-1:0]    m_tuser;
	logic                           m_tlast;
	logic                           cfg_wen = 1'b0;
	logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [srr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned failures;
	int unsigned pending;
	int unsigned deliveries_seen;
	int unsigned acks_seen;
	int unsigned cycle_count = 0;
	int unsigned frames_sent = 0;
	int unsigned settings_written = 0;
	logic        quiet = 1'b0;
	logic [15:0] base = '0;
	int unsigned win_plan [8] = '{16, 1, 0, 31, 5, 12, 3, 16};

	selective_repeat_receiver #(.WINDOW_DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	srr_delivery_checker #(.WINDOW_DEPTH(DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending),
		.deliveries_seen(deliveries_seen),
		.acks_seen(acks_seen)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 19);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_frame(input logic [15:0] seq, input logic [31:0] tag,
			input logic [10:0] len);
		srr_pkg::srr_item_t frame;
		frame.seq_num = seq;
		frame.payload_tag = tag;
		frame.payload_len = len;
		while (!quiet && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(srr_pkg::TDATA_W - srr_pkg::ITEM_W){1'b0}}, frame};
		do @(posedge clk); while (!s_tready);
		frames_sent++;
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(input logic [15:0] ws_data, input logic [15:0] fc);
		cfg_wen <= 1'b1;
		cfg_index <= srr_pkg::CFG_WIN_SLOTS;
		cfg_data <= ws_data;
		@(posedge clk);
		cfg_index <= srr_pkg::CFG_FRAME_COUNT;
		cfg_data <= fc;
		@(posedge clk);
		cfg_wen <= 1'b0;
		settings_written++;
	endtask

	task automatic send_noise(input int unsigned span);
		logic [15:0] seq;
		case ($urandom_range(2))
			0: seq = 16'($urandom);
			1: seq = base - 16'($urandom_range(span + 2, 1));
			default: seq = base + 16'(span) + 16'($urandom_range(3));
		endcase
		send_frame(seq, $urandom, 11'($urandom_range(2047)));
	endtask

	// One window's worth of frames starting at base, in order or shuffled,
	// with stray frames and retransmissions mixed in.
	task automatic send_block(input int unsigned span);
		logic [15:0] order [DEPTH];
		logic [15:0] tmp;
		int unsigned j;
		for (int i = 0; i < span; i++) begin
			order[i] = base + 16'(i);
		end
		if ($urandom_range(2) != 0) begin
			for (int i = span - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (int i = 0; i < span; i++) begin
			if ($urandom_range(5) == 0) begin
				send_noise(span);
			end
			if (i > 0 && $urandom_range(7) == 0) begin
				send_frame(order[$urandom_range(i - 1)], $urandom, 11'($urandom_range(2047)));
			end
			send_frame(order[i], $urandom, 11'($urandom_range(2047)));
		end
		base = base + 16'(span);
	endtask

	initial begin
		int unsigned span;
		int unsigned start;
		logic [15:0] ws_data;
		logic [15:0] fc;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, window edges, stale and far frames, an overwrite,
		// and a full-window release with the default settings.
		send_frame(16'd0, 32'hFFFF_FFFF, 11'h7FF);
		send_frame(16'd16, 32'h0, 11'h0);
		send_frame(16'd17, $urandom, 11'($urandom_range(2047)));
		send_frame(16'd0, $urandom, 11'($urandom_range(2047)));
		send_frame(16'h8000, $urandom, 11'($urandom_range(2047)));
		send_frame(16'd3, $urandom, 11'($urandom_range(2047)));
		send_frame(16'd3, $urandom, 11'($urandom_range(2047)));
		for (int s = 15; s >= 4; s--) begin
			send_frame(16'(s), $urandom, 11'($urandom_range(2047)));
		end
		send_frame(16'd2, $urandom, 11'($urandom_range(2047)));
		send_frame(16'd1, $urandom, 11'($urandom_range(2047)));
		wait_for_drain();
		write_config(16'd16, 16'd0);
		send_frame(16'd17, $urandom, 11'($urandom_range(2047)));
		send_frame(16'hFFFF, $urandom, 11'($urandom_range(2047)));
		base = 16'd17;

		for (int p = 0; p < 8; p++) begin
			wait_for_drain();
			quiet <= (p == 0);
			ws_data = 16'($urandom);
			ws_data[4:0] = win_plan[p][4:0];
			fc = (p == 5) ? base + 16'd20 : 16'hFFFF;
			write_config(ws_data, fc);
			span = (win_plan[p] == 0) ? 1 : ((win_plan[p] > DEPTH) ? DEPTH : win_plan[p]);
			start = frames_sent;
			while (frames_sent - start < PHASE_FRAMES) begin
				send_block(span);
			end
			if (base > fc) begin
				base = fc;
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);

		$display("Sent %0d frames under %0d register settings; checked %0d deliveries and %0d acks.",
			frames_sent, settings_written, deliveries_seen, acks_seen);
		$display("Windows of 1 to 16 slots, stale, duplicate, far and post-completion frames ran.");
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
